// File: hdl/lcrim_pkg.sv
// Package for the LC reciprocal inductance meter: widths, reset values, codes.
package lcrim_pkg;

  localparam int TimerBitsDefault = 16;

  localparam logic [7:0]  MinOverflowsReset  = 8'd64;
  localparam logic [7:0]  MaxOverflowsReset  = 8'd128;
  localparam logic [31:0] ReferenceRateReset = 32'd4096000000;
  localparam logic [31:0] InductanceCoefReset = 32'd12969101;
  localparam logic [31:0] ZeroOffsetReset    = 32'd1915;

  localparam logic [25:0] RunMax  = 26'd33554431;
  localparam logic [23:0] TickMax = 24'd16777215;

  // Configuration register indexes
  localparam logic [7:0] RegMinOverflows  = 8'd0;
  localparam logic [7:0] RegMaxOverflows  = 8'd1;
  localparam logic [7:0] RegReferenceRate = 8'd2;
  localparam logic [7:0] RegInductanceCoef = 8'd3;
  localparam logic [7:0] RegZeroOffset    = 8'd4;

  // Event kinds and result status codes
  localparam logic ActOverflow = 1'b0;
  localparam logic ActCapture  = 1'b1;
  localparam logic StatDone    = 1'b0;
  localparam logic StatNoRes   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

endpackage

// File: hdl/lc_reciprocal_inductance_meter.sv
// Top level of the LC reciprocal inductance meter: tallies, sequencer, mul/div unit.
//
//  channel  | direction | handshake               | payload
//  s_axis   | in        | s_axis_tvalid/tready    | tuser: action; tdata: timer, button
//  m_axis   | out       | m_axis_tvalid/tready    | tuser: status; tdata: results
//  cfg      | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// An overflow event that reports nothing, or a capture that leaves the gate open,
// is taken in IDLE, which stays ready; an overflow that reports a dead oscillator
// passes through FIN to load the output register. A capture that closes the gate
// goes through 7 multiply steps on the shared 32x16 multiplier, two runs of the
// radix-2 divider and the output load in FIN before the next transfer is taken.
// The input is not ready while a gate result is computed or waits for a free
// output register. Reset loads the register defaults; the cfg port never stalls.
module lc_reciprocal_inductance_meter #(
  parameter int TIMER_BITS = lcrim_pkg::TimerBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,   // [15:0] captured timer count, [16] calibrate_button
  input  logic         s_axis_tuser,   // [0] action
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [167:0] m_axis_tdata,   // edge_total, tick_total, frequency_hz,
                                       // raw_inductance_nh, adjusted_inductance_nh,
                                       // offset_nh
  output logic         m_axis_tuser,   // [0] status
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int MaskBits = (TIMER_BITS < 16) ? TIMER_BITS : 16;
  localparam logic [15:0] TvMask = 16'((17'(1) << MaskBits) - 17'(1));
  localparam logic [26:0] OvfInc = 27'(1) << TIMER_BITS;

  // Configuration registers
  logic [7:0]  min_ovf_q, max_ovf_q;
  logic [31:0] rate_q, coef_q;
  logic [31:0] off_q, off_d;

  // Tallies
  logic [7:0]        ovf_q, ovf_d;
  logic [15:0]       edge_q, edge_d;
  logic signed [25:0] run_q, run_d;

  // Sequencer and datapath
  lcrim_pkg::state_e state_q, state_d;
  logic [2:0]  step_q, step_d;
  logic        phase_q, phase_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        btn_q, btn_d;
  logic [15:0] e_q, e_d;
  logic [23:0] t_q, t_d;
  logic [47:0] fnum_q, fnum_d;
  logic [47:0] sq_q, sq_d;
  logic [31:0] dsq_q, dsq_d;
  logic [79:0] pr_q, pr_d;
  logic [47:0] dvd_q, dvd_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] freq_q, freq_d;
  logic        stat_q, stat_d;
  logic        ovalid_q, ovalid_d;
  logic [167:0] odata_q, odata_d;
  logic        ostat_q, ostat_d;

  logic        in_xfer;
  logic [15:0] tv;
  logic [26:0] run_sum;
  logic signed [26:0] ticks;
  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic [47:0] mul_p;
  logic [31:0] dvs;
  logic [32:0] rem_sh;
  logic        qbit;
  logic [31:0] raw;
  logic [31:0] off_new;
  logic signed [33:0] adj;
  logic [31:0] adj_sat;
  logic        out_free;

  assign s_axis_tready = (state_q == lcrim_pkg::ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign tv            = s_axis_tdata[15:0] & TvMask;
  assign run_sum       = {run_q[25], run_q} + OvfInc;
  assign ticks         = {run_q[25], run_q} + $signed({11'd0, tv});
  assign out_free      = !ovalid_q || m_axis_tready;

  // Shared multiplier operands by step
  always_comb begin
    mul_a = coef_q;
    mul_b = 16'd0;
    case (step_q)
      3'd0: begin mul_a = rate_q;          mul_b = e_q;                end
      3'd1: begin mul_a = {8'd0, t_q};     mul_b = t_q[15:0];          end
      3'd2: begin mul_a = {8'd0, t_q};     mul_b = {8'd0, t_q[23:16]}; end
      3'd3: begin mul_a = {16'd0, e_q};    mul_b = e_q;                end
      3'd4: begin mul_a = coef_q;          mul_b = sq_q[15:0];         end
      3'd5: begin mul_a = coef_q;          mul_b = sq_q[31:16];        end
      3'd6: begin mul_a = coef_q;          mul_b = sq_q[47:32];        end
      default: begin mul_a = coef_q;       mul_b = 16'd0;              end
    endcase
  end
  assign mul_p = 48'(mul_a) * 48'(mul_b);

  // Shared restoring divider step
  assign dvs    = phase_q ? dsq_q : {8'd0, t_q};
  assign rem_sh = {rem_q, dvd_q[47]};
  assign qbit   = (rem_sh >= {1'b0, dvs});

  // Result assembly for a closed gate
  assign raw     = (dvd_q[47:32] != 16'd0) ? 32'hFFFF_FFFF : dvd_q[31:0];
  assign off_new = btn_q ? ((raw[31]) ? 32'h7FFF_FFFF : raw) : off_q;
  assign adj     = $signed({2'b00, raw}) - $signed({{2{off_new[31]}}, off_new});
  always_comb begin
    if (adj > 34'sd2147483647) begin
      adj_sat = 32'h7FFF_FFFF;
    end else if (adj < -34'sd2147483648) begin
      adj_sat = 32'h8000_0000;
    end else begin
      adj_sat = adj[31:0];
    end
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    btn_d    = btn_q;
    e_d      = e_q;
    t_d      = t_q;
    fnum_d   = fnum_q;
    sq_d     = sq_q;
    dsq_d    = dsq_q;
    pr_d     = pr_q;
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    freq_d   = freq_q;
    stat_d   = stat_q;
    ovf_d    = ovf_q;
    edge_d   = edge_q;
    run_d    = run_q;
    off_d    = off_q;
    ovalid_d = ovalid_q;
    odata_d  = odata_q;
    ostat_d  = ostat_q;

    // drop the output once taken
    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      lcrim_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (s_axis_tuser == lcrim_pkg::ActOverflow) begin
            ovf_d = (ovf_q == 8'hFF) ? ovf_q : ovf_q + 8'd1;
            run_d = ($signed(run_sum) > $signed({1'b0, lcrim_pkg::RunMax}))
                    ? lcrim_pkg::RunMax : run_sum[25:0];
            if (ovf_d > max_ovf_q) begin
              stat_d  = lcrim_pkg::StatNoRes;
              state_d = lcrim_pkg::ST_FIN;
            end
          end else begin
            edge_d = (edge_q == 16'hFFFF) ? edge_q : edge_q + 16'd1;
            if (ovf_q >= min_ovf_q) begin
              e_d    = edge_d;
              edge_d = 16'd0;
              ovf_d  = 8'd0;
              run_d  = 26'(-$signed({1'b0, tv}));
              btn_d  = s_axis_tdata[16];
              if (ticks < 0) begin
                t_d = 24'd0;
              end else if (ticks > $signed({3'd0, lcrim_pkg::TickMax})) begin
                t_d = lcrim_pkg::TickMax;
              end else begin
                t_d = ticks[23:0];
              end
              stat_d  = lcrim_pkg::StatDone;
              step_d  = 3'd0;
              state_d = lcrim_pkg::ST_MUL;
            end
          end
        end
      end

      lcrim_pkg::ST_MUL: begin
        case (step_q)
          3'd0: fnum_d = mul_p;
          3'd1: sq_d   = mul_p;
          3'd2: sq_d   = sq_q + (mul_p << 16);
          3'd3: dsq_d  = mul_p[31:0];
          3'd4: pr_d   = 80'(mul_p);
          3'd5: pr_d   = pr_q + (80'(mul_p) << 16);
          3'd6: pr_d   = pr_q + (80'(mul_p) << 32);
          default: pr_d = pr_q;
        endcase
        step_d = step_q + 3'd1;
        if (step_q == 3'd6) begin
          phase_d = 1'b0;
          cnt_d   = 6'd0;
          rem_d   = 32'd0;
          dvd_d   = fnum_d;
          state_d = lcrim_pkg::ST_DIV;
        end
      end

      lcrim_pkg::ST_DIV: begin
        rem_d = qbit ? 32'(rem_sh - {1'b0, dvs}) : rem_sh[31:0];
        dvd_d = {dvd_q[46:0], qbit};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd47) begin
          if (!phase_q) begin
            // hold frequency, start inductance division
            if (t_q == 24'd0 || dvd_d[47:32] != 16'd0) begin
              freq_d = 32'hFFFF_FFFF;
            end else begin
              freq_d = dvd_d[31:0];
            end
            phase_d = 1'b1;
            cnt_d   = 6'd0;
            rem_d   = 32'd0;
            dvd_d   = pr_q[79:32];
          end else begin
            state_d = lcrim_pkg::ST_FIN;
          end
        end
      end

      lcrim_pkg::ST_FIN: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          ostat_d  = stat_q;
          if (stat_q == lcrim_pkg::StatNoRes) begin
            odata_d = {off_q, 136'd0};
          end else begin
            off_d   = off_new;
            odata_d = {off_new, adj_sat, raw, freq_q, t_q, e_q};
          end
          state_d = lcrim_pkg::ST_IDLE;
        end
      end

      default: state_d = lcrim_pkg::ST_IDLE;
    endcase

    // configuration write of the offset also loads the live offset
    if (cfg_valid_i && cfg_index_i == lcrim_pkg::RegZeroOffset) begin
      off_d = cfg_data_i;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lcrim_pkg::ST_IDLE;
      step_q    <= 3'd0;
      phase_q   <= 1'b0;
      cnt_q     <= 6'd0;
      ovf_q     <= 8'd0;
      edge_q    <= 16'd0;
      run_q     <= 26'sd0;
      off_q     <= lcrim_pkg::ZeroOffsetReset;
      ovalid_q  <= 1'b0;
      min_ovf_q <= lcrim_pkg::MinOverflowsReset;
      max_ovf_q <= lcrim_pkg::MaxOverflowsReset;
      rate_q    <= lcrim_pkg::ReferenceRateReset;
      coef_q    <= lcrim_pkg::InductanceCoefReset;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      edge_q   <= edge_d;
      run_q    <= run_d;
      off_q    <= off_d;
      ovalid_q <= ovalid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          lcrim_pkg::RegMinOverflows:   min_ovf_q <= cfg_data_i[7:0];
          lcrim_pkg::RegMaxOverflows:   max_ovf_q <= cfg_data_i[7:0];
          lcrim_pkg::RegReferenceRate:  rate_q    <= cfg_data_i;
          lcrim_pkg::RegInductanceCoef: coef_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    btn_q   <= btn_d;
    e_q     <= e_d;
    t_q     <= t_d;
    fnum_q  <= fnum_d;
    sq_q    <= sq_d;
    dsq_q   <= dsq_d;
    pr_q    <= pr_d;
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    freq_q  <= freq_d;
    stat_q  <= stat_d;
    odata_q <= odata_d;
    ostat_q <= ostat_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ostat_q;

endmodule

// File: tb/tb.sv
// Testbench for the LC reciprocal inductance meter: random stream traffic and a predictor.
`timescale 1ns / 100ps

module tb;

  localparam int CycleLimit = 200000;
  localparam int SettleCycles = 200;

  typedef struct {
    logic        action;
    logic [15:0] timer;
    logic        button;
  } event_t;

  typedef struct packed {
    logic               status;
    logic [15:0]        edges;
    logic [23:0]        ticks;
    logic [31:0]        freq;
    logic [31:0]        raw;
    logic signed [31:0] adj;
    logic signed [31:0] offset;
  } meas_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [23:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [167:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [7:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;

  lc_reciprocal_inductance_meter dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor copy of the configuration and the tallies
  logic [7:0]         min_ovf, max_ovf;
  logic [31:0]        ref_rate, ind_coef;
  logic signed [31:0] zero_offset;
  int unsigned        ovf_tally, edge_tally;
  int                 run_ticks;

  event_t pending_events[$];
  event_t cur_event;
  meas_t  expected_meas[$];
  int     cycle_count = 0;
  int     mismatches = 0;
  int     events_sent = 0, gates_seen = 0, dead_seen = 0;
  int     settings_used = 1;

  function automatic logic [31:0] inductance_nh(longint unsigned t, longint unsigned e);
    longint unsigned n, d, q, r, f2, a, b, res;
    n = t * t;
    d = e * e;
    if (d == 0) return '0;
    q = n / d;
    r = n % d;
    f2 = (longint'(ind_coef) * r) / d;
    a = longint'(ind_coef) * (q & 64'hFFFF_FFFF);
    b = longint'(ind_coef) * (q >> 32);
    res = b + ((a + f2) >> 32);
    return (res > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : res[31:0];
  endfunction

  // Advance the predicted state by one event; queue a result when one is due
  function automatic void predict_event(event_t ev);
    meas_t m;
    longint tk, adjv;
    longint unsigned t, e, fq;
    m = '{default: '0};
    if (ev.action == lcrim_pkg::ActOverflow) begin
      if (ovf_tally < 255) ovf_tally++;
      run_ticks = (run_ticks + 65536 > int'(lcrim_pkg::RunMax)) ? int'(lcrim_pkg::RunMax)
                                                                : run_ticks + 65536;
      if (ovf_tally > max_ovf) begin
        m.status = lcrim_pkg::StatNoRes;
        m.offset = zero_offset;
        expected_meas.push_back(m);
        dead_seen++;
      end
      return;
    end
    if (edge_tally < 65535) edge_tally++;
    if (ovf_tally < min_ovf) return;
    tk = longint'(run_ticks) + ev.timer;
    run_ticks = -int'(ev.timer);
    e = edge_tally;
    edge_tally = 0;
    ovf_tally = 0;
    if (tk < 0) tk = 0;
    if (tk > longint'(lcrim_pkg::TickMax)) tk = longint'(lcrim_pkg::TickMax);
    t = tk;
    if (t == 0) fq = 64'hFFFF_FFFF;
    else begin
      fq = (longint'(ref_rate) * e) / t;
      if (fq > 64'hFFFF_FFFF) fq = 64'hFFFF_FFFF;
    end
    m.status = lcrim_pkg::StatDone;
    m.edges = e[15:0];
    m.ticks = t[23:0];
    m.freq = fq[31:0];
    m.raw = inductance_nh(t, e);
    if (ev.button) zero_offset = (m.raw > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : m.raw;
    adjv = longint'(m.raw) - longint'(zero_offset);
    if (adjv > 64'sd2147483647) adjv = 64'sd2147483647;
    if (adjv < -64'sd2147483648) adjv = -64'sd2147483648;
    m.adj = adjv[31:0];
    m.offset = zero_offset;
    expected_meas.push_back(m);
    gates_seen++;
  endfunction

  // Idle about 37 times in 100, but not inside a quiet window
  function automatic bit idle_now();
    if (cycle_count > 2500 && cycle_count < 4500) return 1'b0;
    return $urandom_range(99) < 37;
  endfunction

  // Drive source transfers from the pending queue
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_event(cur_event);
        events_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_events.size() > 0 && !idle_now()) begin
          cur_event = pending_events.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= cur_event.action;
          s_axis_tdata <= {7'b0, cur_event.button, cur_event.timer};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Check each result transfer against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !idle_now();
      if (m_axis_tvalid && m_axis_tready) begin
        meas_t got, want;
        got.status = m_axis_tuser;
        {got.offset, got.adj, got.raw, got.freq, got.ticks, got.edges} = m_axis_tdata;
        if (expected_meas.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result status=%0d tdata=%h", got.status, m_axis_tdata);
        end else begin
          want = expected_meas.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"ERROR: result mismatch\n  exp st=%0d e=%0d t=%0d f=%0d raw=%0d adj=%0d",
                        " off=%0d\n  got st=%0d e=%0d t=%0d f=%0d raw=%0d adj=%0d off=%0d"},
                       want.status, want.edges, want.ticks, want.freq, want.raw, want.adj,
                       want.offset, got.status, got.edges, got.ticks, got.freq, got.raw,
                       got.adj, got.offset);
          end
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_meas.size());
      $display("** lc_reciprocal_inductance_meter: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      lcrim_pkg::RegMinOverflows:   min_ovf = val[7:0];
      lcrim_pkg::RegMaxOverflows:   max_ovf = val[7:0];
      lcrim_pkg::RegReferenceRate:  ref_rate = val;
      lcrim_pkg::RegInductanceCoef: ind_coef = val;
      lcrim_pkg::RegZeroOffset:     zero_offset = val;
      default: ;
    endcase
  endtask

  task automatic write_all(logic [7:0] mn, logic [7:0] mx, logic [31:0] rate,
                           logic [31:0] coef, logic [31:0] off);
    write_reg(lcrim_pkg::RegMinOverflows, 32'(mn));
    write_reg(lcrim_pkg::RegMaxOverflows, 32'(mx));
    write_reg(lcrim_pkg::RegReferenceRate, rate);
    write_reg(lcrim_pkg::RegInductanceCoef, coef);
    write_reg(lcrim_pkg::RegZeroOffset, off);
    settings_used++;
  endtask

  // Hold until every queued event went out and every result came back
  task automatic drain();
    while (pending_events.size() != 0 || s_axis_tvalid || expected_meas.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic void push_event(logic act, logic [15:0] tv, logic btn);
    pending_events.push_back('{action: act, timer: tv, button: btn});
  endfunction

  function automatic logic [15:0] rand_timer();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'd1;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(100000, 1);
      default: return $urandom;
    endcase
  endfunction

  // Queue one gate: overflows with stray captures, then the closing capture
  function automatic void push_gate();
    int n;
    n = int'($urandom_range(int'(max_ovf) + 2, 0));
    if (n > 10) n = int'($urandom_range(10, int'(min_ovf)));
    for (int i = 0; i < n; i++) begin
      push_event(lcrim_pkg::ActOverflow, rand_timer(), 1'($urandom_range(1)));
      if ($urandom_range(2) == 0)
        push_event(lcrim_pkg::ActCapture, rand_timer(), $urandom_range(3) == 0);
    end
    push_event(lcrim_pkg::ActCapture, rand_timer(), $urandom_range(3) == 0);
  endfunction

  initial begin
    logic [7:0] mn, mx;
    min_ovf = lcrim_pkg::MinOverflowsReset;
    max_ovf = lcrim_pkg::MaxOverflowsReset;
    ref_rate = lcrim_pkg::ReferenceRateReset;
    ind_coef = lcrim_pkg::InductanceCoefReset;
    zero_offset = lcrim_pkg::ZeroOffsetReset;
    ovf_tally = 0;
    edge_tally = 0;
    run_ticks = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: one full default gate
    for (int i = 0; i < 66; i++) begin
      push_event(lcrim_pkg::ActOverflow, rand_timer(), 1'b0);
      if (i % 9 == 0) push_event(lcrim_pkg::ActCapture, rand_timer(), 1'b0);
    end
    push_event(lcrim_pkg::ActCapture, 16'h1234, 1'b0);
    drain();

    // Directed: extreme registers, short gates, dead oscillator, calibration
    write_all(8'd1, 8'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
    push_event(lcrim_pkg::ActCapture, 16'hFFFF, 1'b1);
    push_event(lcrim_pkg::ActOverflow, 16'h0000, 1'b0);
    push_event(lcrim_pkg::ActCapture, 16'h0000, 1'b0);
    push_event(lcrim_pkg::ActOverflow, 16'hFFFF, 1'b1);
    push_event(lcrim_pkg::ActCapture, 16'hFFFF, 1'b1);
    for (int i = 0; i < 5; i++) push_event(lcrim_pkg::ActOverflow, 16'h0000, 1'b0);
    push_event(lcrim_pkg::ActCapture, 16'h0001, 1'b0);
    push_event(lcrim_pkg::ActCapture, 16'h0000, 1'b0);
    push_event(lcrim_pkg::ActOverflow, 16'h8000, 1'b0);
    push_event(lcrim_pkg::ActCapture, 16'h7FFF, 1'b1);
    drain();
    write_all(8'd2, 8'd2, 32'd1, 32'd1, 32'h7FFF_FFFF);
    for (int i = 0; i < 4; i++) push_event(lcrim_pkg::ActOverflow, 16'h5555, 1'b1);
    push_event(lcrim_pkg::ActCapture, 16'hAAAA, 1'b0);
    push_event(lcrim_pkg::ActOverflow, 16'h0000, 1'b0);
    push_event(lcrim_pkg::ActOverflow, 16'h0000, 1'b0);
    push_event(lcrim_pkg::ActCapture, 16'h0000, 1'b1);
    drain();

    // Random phases with random settings
    for (int ph = 0; ph < 7; ph++) begin
      mn = (ph == 3) ? 8'd255 : 8'($urandom_range(6, 1));
      mx = ($urandom_range(3) == 0) ? 8'd255 : 8'(mn + $urandom_range(8));
      if (mx < mn) mx = 8'd255;
      write_all(mn, mx, rand_word(), rand_word(), $urandom);
      if (mn == 8'd255) begin
        // Long gate: tick clamp and tally saturation
        for (int i = 0; i < 260; i++) push_event(lcrim_pkg::ActOverflow, rand_timer(), 1'b0);
        push_event(lcrim_pkg::ActCapture, rand_timer(), 1'($urandom_range(1)));
      end else begin
        for (int g = 0; g < 4; g++) begin
          if ($urandom_range(9) == 0)
            push_event(1'($urandom_range(1)), rand_timer(), 1'($urandom_range(1)));
          else
            push_gate();
        end
      end
      drain();
    end

    $display("sent %0d events over %0d register settings: %0d gate results, %0d dead-oscillator",
             events_sent, settings_used, gates_seen, dead_seen);
    $display("reports; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("** lc_reciprocal_inductance_meter: PASSED **");
    end else begin
      $display("** lc_reciprocal_inductance_meter: FAILED **");
    end
    $finish;
  end

endmodule
